[rtl/core/mfbro_pkg.sv]
// Shared types and constants of the monochrome frame store raster core.
package mfbro_pkg;

  localparam int          WORD_BITS   = 16;
  localparam int          IN_TDATA_W  = 56;
  localparam int          OUT_TDATA_W = 16;
  localparam logic [15:0] FULL_MASK   = 16'hFFFF;
  localparam logic [31:0] BYTE_AT_TOP = 32'hFF00_0000;

  typedef enum logic [2:0] {
    CMD_SET_RECT  = 3'd0,
    CMD_CLR_RECT  = 3'd1,
    CMD_INV_RECT  = 3'd2,
    CMD_VLINE     = 3'd3,
    CMD_PIXEL     = 3'd4,
    CMD_BLIT_WIN  = 3'd5,
    CMD_BLIT_BYTE = 3'd6,
    CMD_READ      = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] x_first;
    logic [6:0] y_first;
    logic [7:0] x_last;
    logic [6:0] y_last;
    logic [7:0] blit_width;
    logic [6:0] blit_height;
    logic [7:0] pixel_byte;
    logic       invert;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        ignored;
  } res_t;

endpackage

[rtl/core/mfbro_store.sv]
// Frame word memory with registered read and a clearing pass after reset.
module mfbro_store import mfbro_pkg::*; #(
  parameter int DEPTH = 1800,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic [AW-1:0]        rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  output logic                 busy
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;
  logic [AW-1:0]        clr_cnt_r;
  logic                 busy_r;
  logic                 we;
  logic [AW-1:0]        wa;
  logic [WORD_BITS-1:0] wd;

  always_comb begin
    if (busy_r) begin
      we = 1'b1;
      wa = clr_cnt_r;
      wd = '0;
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_cnt_r <= '0;
    end else if (busy_r) begin
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        busy_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

[rtl/core/mfbro_engine.sv]
// Command decode and read-modify-write word walker over the frame store.
module mfbro_engine import mfbro_pkg::*; #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 120,
  parameter int COORD_ORIGIN  = 1,
  localparam int AW = $clog2(((SCREEN_WIDTH + 15) / 16) * SCREEN_HEIGHT)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  item_t                item,
  input  logic                 mem_busy,
  output logic                 mem_wr_en,
  output logic [AW-1:0]        mem_wr_addr,
  output logic [WORD_BITS-1:0] mem_wr_data,
  output logic [AW-1:0]        mem_rd_addr,
  input  logic [WORD_BITS-1:0] mem_rd_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_t                 res
);

  localparam int WPR   = (SCREEN_WIDTH + 15) / 16;
  localparam int XW    = $clog2(SCREEN_WIDTH);
  localparam int YW    = $clog2(SCREEN_HEIGHT);
  localparam int WW    = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int CXW   = (($clog2(SCREEN_WIDTH + 1) > 8) ? $clog2(SCREEN_WIDTH + 1) : 8) + 1;
  localparam int CYW   = (($clog2(SCREEN_HEIGHT + 1) > 7) ? $clog2(SCREEN_HEIGHT + 1) : 7) + 1;
  localparam int X_MAX = SCREEN_WIDTH - 1 + COORD_ORIGIN;
  localparam int Y_MAX = SCREEN_HEIGHT - 1 + COORD_ORIGIN;

  typedef enum logic [1:0] {OP_MERGE, OP_XOR, OP_READ} op_t;
  typedef enum logic [2:0] {S_IDLE, S_SETUP, S_RUN, S_FIN, S_DONE} state_t;

  function automatic logic [XW-1:0] zb_x(input logic [7:0] v);
    logic [CXW-1:0] w;
    w = CXW'(v);
    if (w < CXW'(COORD_ORIGIN)) w = CXW'(COORD_ORIGIN);
    if (w > CXW'(X_MAX)) w = CXW'(X_MAX);
    return XW'(w - CXW'(COORD_ORIGIN));
  endfunction

  function automatic logic [YW-1:0] zb_y(input logic [6:0] v);
    logic [CYW-1:0] w;
    w = CYW'(v);
    if (w < CYW'(COORD_ORIGIN)) w = CYW'(COORD_ORIGIN);
    if (w > CYW'(Y_MAX)) w = CYW'(Y_MAX);
    return YW'(w - CYW'(COORD_ORIGIN));
  endfunction

  state_t               state_r;
  item_t                item_r;
  logic [CXW-1:0]       cur_x_r, left_r, right_r;
  logic [CYW-1:0]       cur_y_r, bottom_r;
  op_t                  op_r;
  logic [YW-1:0]        row_r, row_end_r;
  logic [AW-1:0]        base_r;
  logic [WW-1:0]        col_r, ws_r, we_r;
  logic [WORD_BITS-1:0] lm_r, rm_r, dl_r, dr_r;
  logic                 p_valid_r;
  logic [AW-1:0]        p_addr_r;
  logic [WORD_BITS-1:0] p_mask_r, p_data_r;
  res_t                 res_r;

  logic                 su_go, su_ign, su_win, su_cur;
  op_t                  su_op;
  logic [YW-1:0]        su_row0, su_row1;
  logic [WW-1:0]        su_ws, su_we;
  logic [WORD_BITS-1:0] su_lm, su_rm, su_dl, su_dr;
  logic [CXW-1:0]       su_xs, su_xe, su_cx;
  logic [CYW-1:0]       su_ys, su_ye, su_cy;

  logic [XW-1:0]        rx1, rx2, rxa, rxb, vx;
  logic [YW-1:0]        ry1, ry2, rya, ryb, vy1, vy2;
  logic                 vl_bad, px_bad, bb_bad;
  logic [CXW-1:0]       lim, bnx, xs_raw;
  logic [CYW-1:0]       ys_raw;
  logic [31:0]          keep32, m32, d32;
  logic [7:0]           data8;

  logic [WORD_BITS-1:0] cur_mask, cur_data;
  logic                 last_col, last_row;

  always_comb begin
    rx1 = zb_x(item_r.x_first);
    rx2 = zb_x(item_r.x_last);
    ry1 = zb_y(item_r.y_first);
    ry2 = zb_y(item_r.y_last);
    rxa = (rx1 > rx2) ? rx2 : rx1;
    rxb = (rx1 > rx2) ? rx1 : rx2;
    rya = (ry1 > ry2) ? ry2 : ry1;
    ryb = (ry1 > ry2) ? ry1 : ry2;
    vx  = XW'(CXW'(item_r.x_first) - CXW'(COORD_ORIGIN));
    vy1 = (ry1 > ry2) ? ry2 : ry1;
    vy2 = (ry1 > ry2) ? ry1 : ry2;

    vl_bad = (item_r.y_first == item_r.y_last) ||
             (CYW'(item_r.y_first) > CYW'(Y_MAX)) ||
             (CYW'(item_r.y_last) > CYW'(Y_MAX)) ||
             (CXW'(item_r.x_first) < CXW'(COORD_ORIGIN)) ||
             (CXW'(item_r.x_first) > CXW'(X_MAX));
    px_bad = (CXW'(item_r.x_first) < CXW'(COORD_ORIGIN)) ||
             (CXW'(item_r.x_first) > CXW'(X_MAX)) ||
             (CYW'(item_r.y_first) < CYW'(COORD_ORIGIN)) ||
             (CYW'(item_r.y_first) > CYW'(Y_MAX));
    bb_bad = (cur_y_r >= bottom_r) || (left_r >= right_r) ||
             (cur_y_r >= CYW'(SCREEN_HEIGHT));

    xs_raw = (CXW'(item_r.x_first) < CXW'(COORD_ORIGIN)) ?
             CXW'(COORD_ORIGIN) : CXW'(item_r.x_first);
    ys_raw = (CYW'(item_r.y_first) < CYW'(COORD_ORIGIN)) ?
             CYW'(COORD_ORIGIN) : CYW'(item_r.y_first);
    su_xs  = xs_raw - CXW'(COORD_ORIGIN);
    su_ys  = ys_raw - CYW'(COORD_ORIGIN);
    su_xe  = su_xs + CXW'(item_r.blit_width);
    su_ye  = su_ys + CYW'(item_r.blit_height);
    if (su_xe > CXW'(SCREEN_WIDTH)) su_xe = CXW'(SCREEN_WIDTH);
    if (su_ye > CYW'(SCREEN_HEIGHT)) su_ye = CYW'(SCREEN_HEIGHT);

    lim    = CXW'(SCREEN_WIDTH) - (cur_x_r & ~CXW'(15));
    keep32 = (lim >= CXW'(32)) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF >> lim[4:0]);
    data8  = item_r.pixel_byte ^ {8{item_r.invert}};
    m32    = (BYTE_AT_TOP >> cur_x_r[3:0]) & keep32;
    d32    = {data8, 24'h0} >> cur_x_r[3:0];
    bnx    = cur_x_r + CXW'(8);

    su_go   = 1'b0;
    su_ign  = 1'b0;
    su_win  = 1'b0;
    su_cur  = 1'b0;
    su_op   = OP_MERGE;
    su_row0 = rya;
    su_row1 = ryb;
    su_ws   = WW'(rxa >> 4);
    su_we   = WW'(rxb >> 4);
    su_lm   = FULL_MASK >> rxa[3:0];
    su_rm   = FULL_MASK << (4'd15 - rxb[3:0]);
    su_dl   = FULL_MASK;
    su_dr   = FULL_MASK;
    su_cx   = (bnx >= right_r) ? left_r : bnx;
    su_cy   = (bnx >= right_r) ? cur_y_r + CYW'(1) : cur_y_r;

    unique case (item_r.cmd)
      CMD_SET_RECT, CMD_CLR_RECT, CMD_INV_RECT: begin
        su_ign = (item_r.x_first == item_r.x_last);
        su_go  = !su_ign;
        su_op  = (item_r.cmd == CMD_INV_RECT) ? OP_XOR : OP_MERGE;
        su_dl  = (item_r.cmd == CMD_SET_RECT) ? FULL_MASK : '0;
        su_dr  = su_dl;
      end
      CMD_VLINE: begin
        su_ign  = vl_bad;
        su_go   = !vl_bad;
        su_row0 = vy1;
        su_row1 = vy2;
        su_ws   = WW'(vx >> 4);
        su_we   = WW'(vx >> 4);
        su_lm   = FULL_MASK >> vx[3:0];
        su_rm   = FULL_MASK << (4'd15 - vx[3:0]);
      end
      CMD_PIXEL: begin
        su_ign  = px_bad;
        su_go   = !px_bad;
        su_row0 = YW'(CYW'(item_r.y_first) - CYW'(COORD_ORIGIN));
        su_row1 = YW'(CYW'(item_r.y_first) - CYW'(COORD_ORIGIN));
        su_ws   = WW'(vx >> 4);
        su_we   = WW'(vx >> 4);
        su_lm   = FULL_MASK >> vx[3:0];
        su_rm   = FULL_MASK << (4'd15 - vx[3:0]);
      end
      CMD_BLIT_WIN: begin
        su_win = 1'b1;
      end
      CMD_BLIT_BYTE: begin
        su_ign  = bb_bad;
        su_go   = !bb_bad;
        su_cur  = !bb_bad;
        su_row0 = YW'(cur_y_r);
        su_row1 = YW'(cur_y_r);
        su_ws   = WW'(cur_x_r >> 4);
        su_we   = (m32[15:0] != '0) ? WW'(cur_x_r >> 4) + WW'(1) : WW'(cur_x_r >> 4);
        su_lm   = m32[31:16];
        su_rm   = (m32[15:0] != '0) ? m32[15:0] : FULL_MASK;
        su_dl   = d32[31:16];
        su_dr   = d32[15:0];
      end
      CMD_READ: begin
        su_go   = 1'b1;
        su_op   = OP_READ;
        su_row0 = ry1;
        su_row1 = ry1;
        su_ws   = WW'(rx1 >> 4);
        su_we   = WW'(rx1 >> 4);
      end
      default: begin
        su_go = 1'b0;
      end
    endcase
  end

  always_comb begin
    last_col = (col_r == we_r);
    last_row = (row_r == row_end_r);
    cur_mask = ((col_r == ws_r) ? lm_r : FULL_MASK) & ((col_r == we_r) ? rm_r : FULL_MASK);
    cur_data = (col_r == ws_r) ? dl_r : dr_r;
  end

  assign mem_rd_addr = base_r + AW'(col_r);
  assign mem_wr_en   = p_valid_r && (op_r != OP_READ);
  assign mem_wr_addr = p_addr_r;
  assign mem_wr_data = (op_r == OP_XOR) ? (mem_rd_data ^ p_mask_r) :
                       ((mem_rd_data & ~p_mask_r) | (p_data_r & p_mask_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      p_valid_r <= 1'b0;
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      left_r    <= '0;
      right_r   <= '0;
      bottom_r  <= '0;
    end else begin
      p_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (item_valid && !mem_busy) begin
            item_r  <= item;
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          res_r.read_data <= '0;
          res_r.ignored   <= su_ign;
          op_r      <= su_op;
          row_r     <= su_row0;
          row_end_r <= su_row1;
          base_r    <= AW'(AW'(su_row0) * AW'(WPR));
          col_r     <= su_ws;
          ws_r      <= su_ws;
          we_r      <= su_we;
          lm_r      <= su_lm;
          rm_r      <= su_rm;
          dl_r      <= su_dl;
          dr_r      <= su_dr;
          if (su_win) begin
            left_r   <= su_xs;
            cur_x_r  <= su_xs;
            cur_y_r  <= su_ys;
            right_r  <= su_xe;
            bottom_r <= su_ye;
          end
          if (su_cur) begin
            cur_x_r <= su_cx;
            cur_y_r <= su_cy;
          end
          state_r <= su_go ? S_RUN : S_DONE;
        end
        S_RUN: begin
          p_valid_r <= 1'b1;
          p_addr_r  <= mem_rd_addr;
          p_mask_r  <= cur_mask;
          p_data_r  <= cur_data;
          if (last_col) begin
            if (last_row) begin
              state_r <= S_FIN;
            end else begin
              row_r  <= row_r + YW'(1);
              base_r <= base_r + AW'(WPR);
              col_r  <= ws_r;
            end
          end else begin
            col_r <= col_r + WW'(1);
          end
        end
        S_FIN: begin
          if (op_r == OP_READ) begin
            res_r.read_data <= mem_rd_data;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign item_ready = (state_r == S_IDLE) && !mem_busy;
  assign res_valid  = (state_r == S_DONE);
  assign res        = res_r;

endmodule

[rtl/core/mono_framebuffer_raster_ops_core.sv]
// Top level of the monochrome frame store raster core.
//
// After reset the frame store is cleared one word per cycle, all
// ((SCREEN_WIDTH+15)/16)*SCREEN_HEIGHT words of it (1800 at the default
// size), and in_tready stays low until that pass is done. A command is then
// taken into a setup state, walks every frame word it touches, passes a
// finish state and waits for its result to enter the output register: a
// rectangle touches rows x words spanned, a vertical line one word per row,
// a pixel or read one word, a blit byte one or two words, and a blit window
// or a rejected command goes from setup straight to its result. The words are
// walked through the single-port-write frame memory one per cycle, each read
// and written back on the next cycle. The next command is taken while a
// result still waits in the output register.
module mono_framebuffer_raster_ops_core import mfbro_pkg::*; #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 120,
  parameter int COORD_ORIGIN  = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // x_first, y_first, x_last, y_last, blit_width, blit_height, pixel_byte, invert
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd
  input  logic [2:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // read_data
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // ignored
  output logic                   out_tuser
);

  localparam int WORDS = ((SCREEN_WIDTH + 15) / 16) * SCREEN_HEIGHT;
  localparam int AW    = $clog2(WORDS);

  item_t                item;
  res_t                 res;
  logic                 res_valid, res_ready;
  logic                 mem_busy, mem_wr_en;
  logic [AW-1:0]        mem_wr_addr, mem_rd_addr;
  logic [WORD_BITS-1:0] mem_wr_data, mem_rd_data;
  logic                 out_valid_r;
  res_t                 out_r;

  always_comb begin
    item.cmd         = cmd_t'(in_tuser);
    item.x_first     = in_tdata[7:0];
    item.y_first     = in_tdata[14:8];
    item.x_last      = in_tdata[22:15];
    item.y_last      = in_tdata[29:23];
    item.blit_width  = in_tdata[37:30];
    item.blit_height = in_tdata[44:38];
    item.pixel_byte  = in_tdata[52:45];
    item.invert      = in_tdata[53];
  end

  mfbro_store #(
    .DEPTH (WORDS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .busy    (mem_busy)
  );

  mfbro_engine #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .COORD_ORIGIN  (COORD_ORIGIN)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (in_tvalid),
    .item_ready  (in_tready),
    .item        (item),
    .mem_busy    (mem_busy),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
      if (res_valid) begin
        out_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.read_data;
  assign out_tuser  = out_r.ignored;

endmodule

[rtl/core/mfbro_checker.sv]
// Port-level checks of the frame store raster core, bound to the top level.
module mfbro_checker import mfbro_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("ports active straight after reset");

  a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("rejected command carries data");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken while one is at work");

endmodule

bind mono_framebuffer_raster_ops_core mfbro_checker u_mfbro_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
